### rtl/dqs_pkg.sv
// Shared types, constants and index helpers for the bounded deque with search.
// Used by dqs_mem, dqs_ctrl and bounded_deque_with_search. No dependencies.
`default_nettype none

package dqs_pkg;

	localparam int DQS_CAPACITY = 64;
	localparam int DQS_AW       = $clog2(DQS_CAPACITY);
	localparam int DQS_CW       = $clog2(DQS_CAPACITY + 1);
	localparam int DQS_DW       = 32;

	// operation codes
	localparam logic [2:0] FN_ADD_FRONT    = 3'd0;
	localparam logic [2:0] FN_ADD_BACK     = 3'd1;
	localparam logic [2:0] FN_REMOVE_FRONT = 3'd2;
	localparam logic [2:0] FN_REMOVE_BACK  = 3'd3;
	localparam logic [2:0] FN_SEARCH       = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} dqs_state_t;

	typedef struct packed {
		logic [2:0]               func;
		logic signed [DQS_DW-1:0] value;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic              found;
		logic [DQS_CW-1:0] count;
		logic              empty_res;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [DQS_AW-1:0] waddr;
		logic [DQS_DW-1:0] wdata;
		logic              re;
		logic [DQS_AW-1:0] raddr;
	} mem_cmd_t;

	function automatic logic [DQS_AW-1:0] idx_inc(input logic [DQS_AW-1:0] i);
		return (i == DQS_AW'(DQS_CAPACITY - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [DQS_AW-1:0] idx_dec(input logic [DQS_AW-1:0] i);
		return (i == '0) ? DQS_AW'(DQS_CAPACITY - 1) : i - 1'b1;
	endfunction

	// head + offset, offset below capacity: one compare and subtract
	function automatic logic [DQS_AW-1:0] idx_add(input logic [DQS_AW-1:0] h,
	                                              input logic [DQS_CW-1:0] c);
		logic [DQS_CW:0] s;
		s = (DQS_CW+1)'(h) + (DQS_CW+1)'(c);
		if (s >= (DQS_CW+1)'(DQS_CAPACITY)) begin
			s = s - (DQS_CW+1)'(DQS_CAPACITY);
		end
		return s[DQS_AW-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/dqs_mem.sv
// Entry storage: one write port, one read port, registered read data.
// Depends on dqs_pkg.
`default_nettype none

module dqs_mem
	import dqs_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_cmd_t          cmd,
	output logic [DQS_DW-1:0]      rdata
);

	logic [DQS_DW-1:0] mem_q [DQS_CAPACITY];
	logic [DQS_DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[cmd.waddr] <= cmd.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rdata_q <= mem_q[cmd.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/dqs_ctrl.sv
// Deque control: head/count bookkeeping, the search scan over the entry
// memory, and the pending result. Depends on dqs_pkg.
`default_nettype none

module dqs_ctrl
	import dqs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	output logic                   res_valid,
	input  wire logic              res_take,
	output rsp_t                   res,
	output mem_cmd_t               mem_cmd,
	input  wire logic [DQS_DW-1:0] mem_rdata
);

	dqs_state_t state_q, state_nx;

	logic [DQS_AW-1:0] head_q, head_nx;
	logic [DQS_CW-1:0] count_q, count_nx;
	logic [DQS_DW-1:0] key_q;
	logic [DQS_AW-1:0] ptr_q;
	logic [DQS_CW-1:0] left_q;
	logic              pend_s1, last_s1;
	rsp_t              res_q;

	logic              accept, not_full, not_empty;
	logic              ok_nx, we_nx, go_scan;
	logic [DQS_AW-1:0] waddr_nx;
	logic              issue, hit, scan_done;

	assign accept    = (state_q == ST_IDLE) && req_valid;
	assign not_full  = count_q < DQS_CW'(DQS_CAPACITY);
	assign not_empty = count_q != '0;
	assign issue     = (state_q == ST_SCAN) && (left_q != '0);
	assign hit       = pend_s1 && (mem_rdata == key_q);
	assign scan_done = pend_s1 && (hit || last_s1);

	// effect of one operation on head and count
	always_comb begin
		head_nx  = head_q;
		count_nx = count_q;
		ok_nx    = 1'b0;
		we_nx    = 1'b0;
		waddr_nx = idx_add(head_q, count_q);
		go_scan  = 1'b0;
		case (req.func)
			FN_ADD_FRONT: begin
				if (not_full) begin
					head_nx  = idx_dec(head_q);
					waddr_nx = idx_dec(head_q);
					count_nx = count_q + 1'b1;
					we_nx    = 1'b1;
					ok_nx    = 1'b1;
				end
			end
			FN_ADD_BACK: begin
				if (not_full) begin
					count_nx = count_q + 1'b1;
					we_nx    = 1'b1;
					ok_nx    = 1'b1;
				end
			end
			FN_REMOVE_FRONT: begin
				if (not_empty) begin
					head_nx  = idx_inc(head_q);
					count_nx = count_q - 1'b1;
					ok_nx    = 1'b1;
				end
			end
			FN_REMOVE_BACK: begin
				if (not_empty) begin
					count_nx = count_q - 1'b1;
					ok_nx    = 1'b1;
				end
			end
			FN_SEARCH: begin
				ok_nx   = 1'b1;
				go_scan = not_empty;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = go_scan ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nx = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_take) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall     = (state_q != ST_IDLE);
		res_valid     = (state_q == ST_RESULT);
		res           = res_q;
		mem_cmd.we    = accept && we_nx;
		mem_cmd.waddr = waddr_nx;
		mem_cmd.wdata = req.value;
		mem_cmd.re    = issue;
		mem_cmd.raddr = ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			left_q  <= '0;
		end else begin
			state_q <= state_nx;
			pend_s1 <= issue;
			last_s1 <= issue && (left_q == DQS_CW'(1));
			if (accept) begin
				head_q  <= head_nx;
				count_q <= count_nx;
				left_q  <= count_q;
			end else if (issue) begin
				left_q <= left_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q           <= req.value;
			ptr_q           <= head_q;
			res_q.ok        <= ok_nx;
			res_q.found     <= 1'b0;
			res_q.count     <= count_nx;
			res_q.empty_res <= (count_nx == '0);
		end else begin
			if (issue) begin
				ptr_q <= idx_inc(ptr_q);
			end
			if ((state_q == ST_SCAN) && scan_done) begin
				res_q.found <= hit;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: control, entry memory and
// the response register. Depends on dqs_pkg, dqs_mem and dqs_ctrl.
`default_nettype none

// A double-ended queue of up to DQS_CAPACITY (64) signed 32-bit entries kept
// in a ring inside one synchronous memory. Every request (add front, add
// back, remove front, remove back, search) gives exactly one response with
// ok, found, the entry count after the request and an empty flag. Adding to
// a full queue or removing from an empty one answers ok = 0 and leaves the
// queue as it was; unused function codes answer ok = 0, found = 0. Adds and
// removes: the request is taken and the ring updated, then the response is
// handed to the output register once that register can take it; no new
// request is taken before then. A search reads the stored entries front to
// back through the single memory read port, one entry per cycle, and stops
// at the first match or after the last entry; a search of an empty queue
// reads nothing. The response register lets the next request be taken while
// an earlier response still waits under rsp_stall. There is no clearing
// pass after reset: only entries that were written are ever read.
module bounded_deque_with_search
	import dqs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	mem_cmd_t          mem_cmd;
	logic [DQS_DW-1:0] mem_rdata;
	logic              res_valid, res_take;
	rsp_t              res;

	logic rsp_valid_q;
	rsp_t rsp_q;

	dqs_mem u_mem (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (mem_rdata)
	);

	dqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_cmd   (mem_cmd),
		.mem_rdata (mem_rdata)
	);

	// output register takes a new response when empty or being drained
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.count <= DQS_CW'(DQS_CAPACITY)))
		else $error("response count above capacity");

	// empty flag agrees with count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.empty_res == (rsp.count == '0)))
		else $error("empty flag disagrees with count");

	// a match is only reported by a successful operation
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> rsp.ok)
		else $error("found without ok");

	// a taken request always leaves the control busy in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous one still open");

endmodule

`default_nettype wire
